>>> rtl/core/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg
// Shared constants, types and sizing helpers for the goal range and bearing
// pipeline (CORDIC vectoring for the angle, digit recurrence for the root).
// ----------------------------------------------------------------------------
package grb_pkg;

  // default sizes
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // fixed-point layout
  localparam int PRESCALE  = 24;
  localparam int ATAN_LEN  = 24;
  localparam int ANGLE_W   = 32;
  localparam int HEADING_W = 16;
  localparam int TURN_W    = 16;
  localparam int RANGE_W   = 17;

  localparam logic [RANGE_W-1:0] RANGE_MAX  = '1;
  localparam logic [ANGLE_W-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ROUND_HALF = 32'h0000_8000;

  // configuration register map
  localparam int REG_IDX_W = 1;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_GOAL_X = 1'b0,
    REG_GOAL_Y = 1'b1
  } grb_reg_t;

  // atan(2^-i) as a fraction of a turn, 2^32 = full turn
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // one result as it leaves the pipeline
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [TURN_W-1:0]  turn;
  } grb_result_t;

  // rotation stages actually used
  function automatic int grb_steps(int cs);
    return (cs > ATAN_LEN) ? ATAN_LEN : cs;
  endfunction

  // magnitude bits fed to the squarer, larger values saturate the range
  function automatic int grb_mag_bits(int cb);
    return (cb + 1 > RANGE_W) ? RANGE_W : cb + 1;
  endfunction

  // common depth of both datapaths so results line up
  function automatic int grb_depth(int cs, int cb);
    int c;
    int s;
    c = 1 + grb_steps(cs);
    s = 3 + grb_mag_bits(cb) + 1;
    return (c > s) ? c : s;
  endfunction

endpackage

>>> rtl/core/grb_cordic.sv
// ----------------------------------------------------------------------------
// grb_cordic
// Pipelined CORDIC vectoring unit: one rotation per stage, gives the bearing
// to the goal minus the heading, rounded to a 16-bit fraction of a turn.
// ----------------------------------------------------------------------------
module grb_cordic #(
  parameter int CORDIC_STEPS = grb_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = grb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         advance,
  input  logic signed [COORD_BITS:0]   dx,
  input  logic signed [COORD_BITS:0]   dy,
  input  logic [grb_pkg::HEADING_W-1:0] heading,
  output logic [grb_pkg::TURN_W-1:0]    turn
);
  import grb_pkg::*;

  localparam int NSTEP = grb_steps(CORDIC_STEPS);
  localparam int DEPTH = grb_depth(CORDIC_STEPS, COORD_BITS);
  localparam int XW    = COORD_BITS + PRESCALE + 3;

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ANGLE_W-1:0]   z;
    logic [HEADING_W-1:0] heading;
  } cstage_t;

  cstage_t            st [DEPTH];
  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] rounded;

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    cstage_t nxt;

    if (k == 0) begin : g_init
      logic signed [XW-1:0] ex;
      logic signed [XW-1:0] ey;
      // fold into the right half plane, prescale
      always_comb begin
        ex          = XW'(dx);
        ey          = XW'(dy);
        nxt.zero    = (dx == '0) && (dy == '0);
        nxt.heading = heading;
        if (dx[COORD_BITS]) begin
          nxt.x = (-ex) <<< PRESCALE;
          nxt.y = (-ey) <<< PRESCALE;
          nxt.z = HALF_TURN;
        end else begin
          nxt.x = ex <<< PRESCALE;
          nxt.y = ey <<< PRESCALE;
          nxt.z = '0;
        end
      end
    end else if (k <= NSTEP) begin : g_iter
      localparam int I = k - 1;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      // one micro-rotation toward the x axis
      always_comb begin
        xs  = st[k-1].x >>> I;
        ys  = st[k-1].y >>> I;
        nxt = st[k-1];
        if (!st[k-1].y[XW-1]) begin
          nxt.x = st[k-1].x + ys;
          nxt.y = st[k-1].y - xs;
          nxt.z = st[k-1].z + ATAN_TABLE[I];
        end else begin
          nxt.x = st[k-1].x - ys;
          nxt.y = st[k-1].y + xs;
          nxt.z = st[k-1].z - ATAN_TABLE[I];
        end
      end
    end else begin : g_pass
      // delay to match the square-root path
      assign nxt = st[k-1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[k] <= nxt;
      end
    end
  end

  // subtract heading and round half up to 16 bits
  assign angle   = st[DEPTH-1].zero ? '0 : st[DEPTH-1].z;
  assign rounded = angle + ROUND_HALF;
  assign turn    = rounded[ANGLE_W-1 -: TURN_W] - st[DEPTH-1].heading;

endmodule

>>> rtl/core/grb_sqrt.sv
// ----------------------------------------------------------------------------
// grb_sqrt
// Pipelined distance unit: absolute values, squares, sum, then one root bit
// per stage by digit recurrence; rounds to nearest and saturates.
// ----------------------------------------------------------------------------
module grb_sqrt #(
  parameter int CORDIC_STEPS = grb_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = grb_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        advance,
  input  logic signed [COORD_BITS:0]  dx,
  input  logic signed [COORD_BITS:0]  dy,
  output logic [grb_pkg::RANGE_W-1:0] range
);
  import grb_pkg::*;

  localparam int DEPTH = grb_depth(CORDIC_STEPS, COORD_BITS);
  localparam int MW    = grb_mag_bits(COORD_BITS);
  localparam int SW    = 2 * MW + 1;
  localparam int RTW   = SW + 1;
  localparam int NB    = MW + 1;
  localparam int CMPW  = (NB + 1 > RANGE_W) ? NB + 1 : RANGE_W;

  typedef struct packed {
    logic              sat;
    logic [MW-1:0]     mag_x;
    logic [MW-1:0]     mag_y;
    logic [2*MW-1:0]   sq_x;
    logic [2*MW-1:0]   sq_y;
    logic [SW-1:0]     n;
    logic [RTW-1:0]    root;
  } sstage_t;

  sstage_t         st [DEPTH];
  logic [COORD_BITS:0] ax;
  logic [COORD_BITS:0] ay;
  logic            sat0;
  logic            round_up;
  logic [NB:0]     rr;
  logic [CMPW-1:0] rr_ext;

  // absolute differences
  assign ax = dx[COORD_BITS] ? (-dx) : dx;
  assign ay = dy[COORD_BITS] ? (-dy) : dy;

  // too far for the range field
  if (COORD_BITS + 1 > RANGE_W) begin : g_sat
    assign sat0 = (|ax[COORD_BITS:RANGE_W]) || (|ay[COORD_BITS:RANGE_W]);
  end else begin : g_nosat
    assign sat0 = 1'b0;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    sstage_t nxt;

    if (k == 0) begin : g_abs
      always_comb begin
        nxt       = '0;
        nxt.sat   = sat0;
        nxt.mag_x = ax[MW-1:0];
        nxt.mag_y = ay[MW-1:0];
      end
    end else if (k == 1) begin : g_square
      always_comb begin
        nxt      = st[k-1];
        nxt.sq_x = st[k-1].mag_x * st[k-1].mag_x;
        nxt.sq_y = st[k-1].mag_y * st[k-1].mag_y;
      end
    end else if (k == 2) begin : g_sum
      always_comb begin
        nxt      = st[k-1];
        nxt.n    = {1'b0, st[k-1].sq_x} + {1'b0, st[k-1].sq_y};
        nxt.root = '0;
      end
    end else if (k < 3 + NB) begin : g_digit
      localparam int SH = 2 * (NB - 1 - (k - 3));
      localparam logic [RTW-1:0] BIT = {{(RTW-1){1'b0}}, 1'b1} << SH;
      logic [RTW-1:0] trial;
      // one result bit: subtract the trial value when it fits
      always_comb begin
        trial = st[k-1].root + BIT;
        nxt   = st[k-1];
        if ({1'b0, st[k-1].n} >= trial) begin
          nxt.n    = st[k-1].n - trial[SW-1:0];
          nxt.root = (st[k-1].root >> 1) + BIT;
        end else begin
          nxt.root = st[k-1].root >> 1;
        end
      end
    end else begin : g_pass
      // delay to match the angle path
      assign nxt = st[k-1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[k] <= nxt;
      end
    end
  end

  // round to nearest: remainder above root means above the half point
  assign round_up = {1'b0, st[DEPTH-1].n} > st[DEPTH-1].root;
  assign rr       = {1'b0, st[DEPTH-1].root[NB-1:0]} + (NB+1)'(round_up);
  assign rr_ext   = CMPW'(rr);
  assign range    = (st[DEPTH-1].sat || (rr_ext > CMPW'(RANGE_MAX))) ?
                    RANGE_MAX : rr_ext[RANGE_W-1:0];

endmodule

>>> rtl/core/grb_outbuf.sv
// ----------------------------------------------------------------------------
// grb_outbuf
// Output register with a one-entry skid buffer; the pipeline keeps moving
// while a result waits, and halts only once the skid entry is taken.
// ----------------------------------------------------------------------------
module grb_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pipe_valid,
  input  grb_pkg::grb_result_t pipe_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output grb_pkg::grb_result_t out_data,
  output logic                 advance
);
  import grb_pkg::*;

  logic        skid_valid;
  grb_result_t skid_data;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;
  assign advance  = !skid_valid;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || pipe_valid;
      skid_valid <= 1'b0;
    end else if (!skid_valid && pipe_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, skid entry drains first
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : pipe_data;
    end else if (!skid_valid) begin
      skid_data <= pipe_data;
    end
  end

endmodule

>>> rtl/core/goal_range_and_bearing.sv
// ----------------------------------------------------------------------------
// goal_range_and_bearing
// Distance and counterclockwise turn from a robot pose to a configured goal.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  cfg      in   cfg_write              cfg_index, cfg_data
//  in       in   in_valid / in_stall    position_x, position_y, heading
//  out      out  out_valid / out_stall  range, turn
//
//  One transfer per cycle sustained while in_stall is low. Items pass the
//  front stage, the pipeline and the output register; depth is set by the
//  18 root-bit stages of the square-root path plus abs, square and sum stages.
//  Reset (rst, synchronous) clears the goal registers and all valid bits.
//  in_stall is registered: it rises only when the skid entry holds a result.
// ----------------------------------------------------------------------------
module goal_range_and_bearing #(
  parameter int CORDIC_STEPS = grb_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = grb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [grb_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  position_x,
  input  logic signed [COORD_BITS-1:0]  position_y,
  input  logic [grb_pkg::HEADING_W-1:0] heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [grb_pkg::RANGE_W-1:0]   range,
  output logic [grb_pkg::TURN_W-1:0]    turn
);
  import grb_pkg::*;

  localparam int DEPTH = grb_depth(CORDIC_STEPS, COORD_BITS);

  logic signed [COORD_BITS-1:0] goal_x;
  logic signed [COORD_BITS-1:0] goal_y;
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [HEADING_W-1:0]         hdg;
  logic [DEPTH:0]               vld;
  logic                         advance;
  logic [RANGE_W-1:0]           res_range;
  logic [TURN_W-1:0]            res_turn;
  grb_result_t                  pipe_res;
  grb_result_t                  out_res;

  // goal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
    end else if (cfg_write) begin
      case (grb_reg_t'(cfg_index))
        REG_GOAL_X: goal_x <= cfg_data;
        REG_GOAL_Y: goal_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // front stage: offsets to the goal
  always_ff @(posedge clk) begin
    if (advance) begin
      dx  <= (COORD_BITS+1)'(goal_x) - (COORD_BITS+1)'(position_x);
      dy  <= (COORD_BITS+1)'(goal_y) - (COORD_BITS+1)'(position_y);
      hdg <= heading;
    end
  end

  // valid bits follow the items down the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[DEPTH-1:0], in_valid};
    end
  end

  assign in_stall = !advance;

  grb_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .COORD_BITS  (COORD_BITS)
  ) u_cordic (
    .clk    (clk),
    .advance(advance),
    .dx     (dx),
    .dy     (dy),
    .heading(hdg),
    .turn   (res_turn)
  );

  grb_sqrt #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .COORD_BITS  (COORD_BITS)
  ) u_sqrt (
    .clk    (clk),
    .advance(advance),
    .dx     (dx),
    .dy     (dy),
    .range  (res_range)
  );

  assign pipe_res.range = res_range;
  assign pipe_res.turn  = res_turn;

  grb_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .pipe_valid(vld[DEPTH]),
    .pipe_data (pipe_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .advance   (advance)
  );

  assign range = out_res.range;
  assign turn  = out_res.turn;

endmodule

>>> rtl/core/grb_checker.sv
// ----------------------------------------------------------------------------
// grb_checker
// Port-level checks on the output register, skid entry and reset behavior,
// bound to the top level.
// ----------------------------------------------------------------------------
module grb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [grb_pkg::RANGE_W-1:0]   range,
  input logic [grb_pkg::TURN_W-1:0]    turn
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(range) && $stable(turn))
    else $error("stalled result changed");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // input stalls only after a result was held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  // skid entry never holds data while the output register is empty
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("skid entry full with output empty");

endmodule

bind goal_range_and_bearing grb_checker u_grb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .range    (range),
  .turn     (turn)
);
